// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
package spq_pkg;

    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int HANDLE_BITS   = 4;
    localparam int QLEN_BITS     = 5;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type                       req_type;
        logic [PAYLOAD_BITS-1:0]         payload;
        logic signed [PRIORITY_BITS-1:0] prio;
        logic [HANDLE_BITS-1:0]          handle;
    } t_req;

    typedef struct packed {
        t_status                         status;
        logic [PAYLOAD_BITS-1:0]         out_payload;
        logic signed [PRIORITY_BITS-1:0] out_priority;
        logic [HANDLE_BITS-1:0]          out_handle;
        logic [QLEN_BITS-1:0]            queue_length;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/spq_ctrl.sv =====
// Handshake controller of the stable priority queue.
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_rsp_valid;
    logic   accept;
    logic   can_commit;

    assign o_req_ready  = (r_state == S_IDLE);
    assign accept       = i_req_valid && o_req_ready;
    assign can_commit   = (r_state == S_EXEC) && (!r_rsp_valid || i_rsp_ready);
    assign o_cmd.load   = accept;
    assign o_cmd.commit = can_commit;
    assign o_rsp_valid  = r_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (can_commit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (can_commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/spq_datapath.sv =====
// Sorted shift-register cells, tag map and result register of the queue.
module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spq_pkg::t_dp_cmd i_cmd,
    input  spq_pkg::t_req    i_req,
    output spq_pkg::t_rsp    o_rsp
);
    import spq_pkg::*;

    localparam int TW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int HW   = (TW > HANDLE_BITS) ? TW : HANDLE_BITS;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0]         payload;
        logic signed [PRIORITY_BITS-1:0] prio;
        logic [TW-1:0]                   tag;
    } t_entry;

    t_entry              r_cells [CAPACITY];
    t_entry              n_cells [CAPACITY];
    logic [CNTW-1:0]     r_count, n_count;
    logic [CAPACITY-1:0] r_tag_used, n_tag_used;
    t_req                r_req;
    t_rsp                r_rsp, n_rsp;

    logic [CAPACITY-1:0] valid, gt, ins, match, del, sh;
    logic                found, any_free, is_full, is_empty, do_ins;
    logic [TW-1:0]       free_tag;
    logic [HW-1:0]       tag_ext;
    logic [HW-1:0]       handle_ext;
    t_entry              new_entry;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = (CNTW'(i) < r_count);
            gt[i]    = valid[i] && ($signed(r_cells[i].prio) > $signed(r_req.prio));
            ins[i]   = valid[i] ? gt[i] : (CNTW'(i) == r_count);
            match[i] = valid[i] && (HW'(r_cells[i].tag) == HW'(r_req.handle));
        end
        found    = |match;
        any_free = 1'b0;
        free_tag = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_tag_used[i]) begin
                any_free = 1'b1;
                free_tag = TW'(i);
            end
        end
    end

    always_comb begin
        is_full            = (r_count >= CNTW'(CAPACITY));
        is_empty           = (r_count == '0);
        handle_ext         = HW'(r_req.handle);
        tag_ext            = HW'(free_tag);
        new_entry.payload  = r_req.payload;
        new_entry.prio     = r_req.prio;
        new_entry.tag      = free_tag;
        n_count            = r_count;
        n_tag_used         = r_tag_used;
        n_rsp              = '0;
        n_rsp.status       = ST_OK;
        del                = '0;
        do_ins             = 1'b0;

        case (r_req.req_type) inside
            REQ_ADD: begin
                if (is_full || !any_free) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    do_ins               = 1'b1;
                    n_rsp.out_handle     = tag_ext[HANDLE_BITS-1:0];
                    n_tag_used[free_tag] = 1'b1;
                    n_count              = r_count + CNTW'(1);
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (is_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.out_payload  = r_cells[0].payload;
                    n_rsp.out_priority = r_cells[0].prio;
                    n_rsp.out_handle   = HANDLE_BITS'(HW'(r_cells[0].tag));
                    if (r_req.req_type == REQ_POP) begin
                        del[0]                      = 1'b1;
                        n_tag_used[r_cells[0].tag] = 1'b0;
                        n_count                     = r_count - CNTW'(1);
                    end
                end
            end
            default: begin
                if (!found) begin
                    n_rsp.status = ST_NOT_FOUND;
                end else begin
                    del                           = match;
                    n_tag_used[handle_ext[TW-1:0]] = 1'b0;
                    n_count                       = r_count - CNTW'(1);
                end
            end
        endcase

        n_rsp.queue_length = QLEN_BITS'(n_count);

        sh[0] = del[0];
        for (int i = 1; i < CAPACITY; i++) begin
            sh[i] = sh[i-1] | del[i];
        end

        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
        end
        if (do_ins) begin
            if (ins[0]) n_cells[0] = new_entry;
            for (int i = 1; i < CAPACITY; i++) begin
                if (ins[i-1]) begin
                    n_cells[i] = r_cells[i-1];
                end else if (ins[i]) begin
                    n_cells[i] = new_entry;
                end
            end
        end else begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (sh[i]) n_cells[i] = r_cells[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_tag_used <= '0;
        end else if (i_cmd.commit) begin
            r_count    <= n_count;
            r_tag_used <= n_tag_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.commit) begin
            r_cells <= n_cells;
            r_rsp   <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: controller and datapath.
//
// Requests enter on the request channel (i_req_valid, o_req_ready, i_req) and
// each one yields exactly one response beat on the response channel
// (o_rsp_valid, i_rsp_ready, o_rsp). A request is add, pop, peek or remove by
// handle; entries of equal priority leave in arrival order.
// A request accepted at one clock edge enters S_EXEC in the following cycle;
// its response is registered when S_EXEC commits, which waits while an older
// response is still unread. No new request is taken before the last one has
// committed: the queue captures it in S_IDLE, then updates every cell of the
// sorted shift register at once in S_EXEC.
// While a response waits for i_rsp_ready, one further request is still
// accepted; its execution holds until the waiting beat is taken.
// Synchronous reset (i_rst_n low) empties the queue and frees all tags at
// once; no clearing pass is needed.
module stable_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  spq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output spq_pkg::t_rsp o_rsp
);
    import spq_pkg::*;

    t_dp_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
